// File: rtl/snpi_pkg.sv
// Shared types and constants for the snapshot interpolator.
// Holds position struct, result modes, sequencer states and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package snpi_pkg;

    localparam int SNAP_DEPTH_DEF = 16;
    localparam int POS_W          = 32;
    localparam int TIME_W         = 32;
    localparam int DELAY_W        = 16;
    localparam int KEPT_W         = 5;
    localparam int MODE_W         = 2;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_DELAY = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_EMPTY  = 2'd0,
        MODE_PAST   = 2'd1,
        MODE_INTERP = 2'd2,
        MODE_FUTURE = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_ADDR,
        ST_T_CHECK,
        ST_P_ADDR,
        ST_P_LOAD,
        ST_PP_ADDR,
        ST_PP_LOAD,
        ST_FP_ADDR,
        ST_FP_LOAD,
        ST_DIV_WAIT,
        ST_BLEND,
        ST_BL_WAIT,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// File: rtl/snpi_if.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on snpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface snpi_req_if;
    import snpi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [TIME_W-1:0]        time_ms;
    logic signed [POS_W-1:0]  in_x;
    logic signed [POS_W-1:0]  in_y;
    logic signed [POS_W-1:0]  in_z;

    modport source (output valid, req_type, time_ms, in_x, in_y, in_z, input ready);
    modport sink   (input valid, req_type, time_ms, in_x, in_y, in_z, output ready);
endinterface

interface snpi_rsp_if;
    import snpi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [POS_W-1:0]  out_z;
    logic [MODE_W-1:0]        result_mode;
    logic [KEPT_W-1:0]        kept_count;

    modport source (output valid, out_x, out_y, out_z, result_mode, kept_count,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, result_mode, kept_count,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/snpi_store.sv
// Snapshot ring store: time and position memories, one write and one read port.
// Read data is registered. Depends on snpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module snpi_store #(
    parameter int SNAP_DEPTH = snpi_pkg::SNAP_DEPTH_DEF,
    parameter int AW         = $clog2(SNAP_DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [AW-1:0]             i_wr_addr,
    input  wire logic [snpi_pkg::TIME_W-1:0] i_wr_time,
    input  wire snpi_pkg::t_pos            i_wr_pos,
    input  wire logic [AW-1:0]             i_rd_addr,
    output logic [snpi_pkg::TIME_W-1:0]    o_rd_time,
    output snpi_pkg::t_pos                 o_rd_pos
);
    import snpi_pkg::*;

    logic [TIME_W-1:0] mem_t [SNAP_DEPTH];
    t_pos              mem_p [SNAP_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_t[i_wr_addr] <= i_wr_time;
            mem_p[i_wr_addr] <= i_wr_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_time <= mem_t[i_rd_addr];
        o_rd_pos  <= mem_p[i_rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/snpi_div.sv
// Restoring fractional divider: quot = floor(num * 2^32 / den), one bit a cycle.
// Gives zero when den is zero or num is not below den. Depends on snpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module snpi_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [snpi_pkg::TIME_W-1:0] i_num,
    input  wire logic [snpi_pkg::TIME_W-1:0] i_den,
    output logic                             o_busy,
    output logic [snpi_pkg::TIME_W-1:0]      o_quot
);
    import snpi_pkg::*;

    localparam int QW    = TIME_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [QW-1:0]    r_rem;
    logic [QW-1:0]    r_den;
    logic [QW-1:0]    r_quot;
    logic             r_zero;

    logic [QW:0]      w_shift;
    logic [QW:0]      w_diff;
    logic             w_ge;

    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = w_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= r_cnt != CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_zero <= (i_den == '0) || (i_num >= i_den);
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[QW-1:0] : w_shift[QW-1:0];
            r_quot <= {r_quot[QW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_zero ? '0 : r_quot;

endmodule
`default_nettype wire

// File: rtl/snpi_blend.sv
// Three-axis blend past + trunc((fut - past) * alpha / 2^32) on one shared
// 32x32 multiplier; each axis registers the product, then the sum. Depends on snpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module snpi_blend (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [snpi_pkg::TIME_W-1:0] i_alpha,
    input  wire snpi_pkg::t_pos              i_past,
    input  wire snpi_pkg::t_pos              i_fut,
    output logic                             o_busy,
    output snpi_pkg::t_pos                   o_res
);
    import snpi_pkg::*;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic                 r_busy;
    logic [1:0]           r_axis;
    logic                 r_phase;
    logic [2*POS_W-1:0]   r_prod;
    logic                 r_neg;
    t_pos                 r_res;

    logic [POS_W-1:0]     w_p;
    logic [POS_W-1:0]     w_f;
    logic [POS_W:0]       w_diff;
    logic [POS_W-1:0]     w_mag;
    logic [2*POS_W-1:0]   w_prod;
    logic [POS_W-1:0]     w_sum;

    always_comb begin
        case (r_axis)
            AXIS_X: begin
                w_p = i_past.x;
                w_f = i_fut.x;
            end
            AXIS_Y: begin
                w_p = i_past.y;
                w_f = i_fut.y;
            end
            default: begin
                w_p = i_past.z;
                w_f = i_fut.z;
            end
        endcase
        w_diff = {w_f[POS_W-1], w_f} - {w_p[POS_W-1], w_p};
        w_mag  = w_diff[POS_W] ? POS_W'((POS_W+1)'(0) - w_diff) : w_diff[POS_W-1:0];
        w_prod = {{POS_W{1'b0}}, w_mag} * {{POS_W{1'b0}}, i_alpha};
        w_sum  = r_neg ? (w_p - r_prod[2*POS_W-1:POS_W])
                       : (w_p + r_prod[2*POS_W-1:POS_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_axis  <= AXIS_X;
            r_phase <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_axis  <= AXIS_X;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            r_phase <= !r_phase;
            if (r_phase) begin
                r_axis <= r_axis + 2'd1;
                if (r_axis == AXIS_Z) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !r_phase) begin
            r_prod <= w_prod;
            r_neg  <= w_diff[POS_W];
        end
        if (r_busy && r_phase) begin
            case (r_axis)
                AXIS_X:  r_res.x <= w_sum;
                AXIS_Y:  r_res.y <= w_sum;
                default: r_res.z <= w_sum;
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;

endmodule
`default_nettype wire

// File: rtl/snapshot_interpolator.sv
// Snapshot interpolator top: sequencer, APB register, ring store, divider, blend.
// Push: written to the store when taken in idle. Query: an empty store goes straight
// to the result; else the walk reads one entry at a time (one store read port), then
// fetches a position, or for a blend both positions, then the divider and the blend.
// One item at a time; the next is taken while a result waits in the output register.
// Synchronous reset empties the store (contents undefined, no clearing), delay = 100.
`timescale 1ns / 1ps
`default_nettype none
module snapshot_interpolator #(
    parameter int SNAP_DEPTH = snpi_pkg::SNAP_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    snpi_req_if.sink                         i_req,
    snpi_rsp_if.source                       o_rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [snpi_pkg::APB_AW-1:0] paddr,
    input  wire logic [snpi_pkg::APB_DW-1:0] pwdata,
    output logic [snpi_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import snpi_pkg::*;

    localparam int AW = $clog2(SNAP_DEPTH);
    localparam int CW = $clog2(SNAP_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SNAP_DEPTH - 1);

    t_state              r_state;
    t_state              n_state;
    logic [AW-1:0]       r_newest;
    logic [CW-1:0]       r_count;
    logic [DELAY_W-1:0]  r_delay;
    logic [TIME_W-1:0]   r_client;
    logic [AW-1:0]       r_ptr;
    logic [CW-1:0]       r_idx;
    logic [AW-1:0]       r_fut_ptr;
    logic [TIME_W-1:0]   r_fut_t;
    logic [CW-1:0]       r_past_idx;
    t_pos                r_past_pos;
    t_pos                r_fut_pos;
    t_mode               r_mode;
    logic                r_out_valid;
    t_pos                r_out_pos;
    t_mode               r_out_mode;
    logic [KEPT_W-1:0]   r_out_kept;

    logic                w_accept;
    logic                w_in_ready;
    logic                w_div_start;
    logic                w_bl_start;
    logic                w_out_load;
    logic                w_out_free;
    logic                w_future;
    logic                w_last;
    logic                w_cfg_wr;
    logic [AW-1:0]       w_wr_addr;
    logic [TIME_W:0]     w_client_d;
    logic [TIME_W-1:0]   w_num;
    logic [TIME_W-1:0]   w_den;
    logic [CW-1:0]       w_new_count;
    t_pos                w_in_pos;
    t_pos                w_res_pos;

    logic [TIME_W-1:0]   w_rd_time;
    t_pos                w_rd_pos;
    logic                w_div_busy;
    logic [TIME_W-1:0]   w_alpha;
    logic                w_bl_busy;
    t_pos                w_bl_res;

    snpi_store #(
        .SNAP_DEPTH (SNAP_DEPTH),
        .AW         (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_req.req_type == REQ_PUSH)),
        .i_wr_addr (w_wr_addr),
        .i_wr_time (i_req.time_ms),
        .i_wr_pos  (w_in_pos),
        .i_rd_addr (r_ptr),
        .o_rd_time (w_rd_time),
        .o_rd_pos  (w_rd_pos)
    );

    snpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_alpha)
    );

    snpi_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bl_start),
        .i_alpha (w_alpha),
        .i_past  (r_past_pos),
        .i_fut   (r_fut_pos),
        .o_busy  (w_bl_busy),
        .o_res   (w_bl_res)
    );

    always_comb begin
        w_in_pos.x  = i_req.in_x;
        w_in_pos.y  = i_req.in_y;
        w_in_pos.z  = i_req.in_z;
        w_wr_addr   = (r_newest == LAST_SLOT) ? '0 : r_newest + AW'(1);
        w_client_d  = {1'b0, i_req.time_ms} - (TIME_W+1)'(r_delay);
        w_future    = w_rd_time > r_client;
        w_last      = (r_idx + CW'(1)) == r_count;
        w_num       = r_client - w_rd_time;
        w_den       = r_fut_t - w_rd_time;
        w_out_free  = !r_out_valid || o_rsp.ready;
        w_accept    = i_req.valid && w_in_ready;
        w_new_count = (r_mode == MODE_INTERP) ? r_past_idx + CW'(1) : r_count;
        case (r_mode)
            MODE_INTERP: w_res_pos = w_bl_res;
            MODE_EMPTY:  w_res_pos = '0;
            default:     w_res_pos = r_past_pos;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid && (i_req.req_type == REQ_QUERY)) begin
                    n_state = (r_count == '0) ? ST_DONE : ST_T_ADDR;
                end
            end
            ST_T_ADDR:   n_state = ST_T_CHECK;
            ST_T_CHECK: begin
                if (!w_future) begin
                    n_state = (r_idx == '0) ? ST_P_ADDR : ST_PP_ADDR;
                end else if (w_last) begin
                    n_state = ST_P_ADDR;
                end else begin
                    n_state = ST_T_ADDR;
                end
            end
            ST_P_ADDR:   n_state = ST_P_LOAD;
            ST_P_LOAD:   n_state = ST_DONE;
            ST_PP_ADDR:  n_state = ST_PP_LOAD;
            ST_PP_LOAD:  n_state = ST_FP_ADDR;
            ST_FP_ADDR:  n_state = ST_FP_LOAD;
            ST_FP_LOAD:  n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: n_state = w_div_busy ? ST_DIV_WAIT : ST_BLEND;
            ST_BLEND:    n_state = ST_BL_WAIT;
            ST_BL_WAIT:  n_state = w_bl_busy ? ST_BL_WAIT : ST_DONE;
            ST_DONE:     n_state = w_out_free ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_bl_start  = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE:    w_in_ready  = 1'b1;
            ST_T_CHECK: w_div_start = !w_future && (r_idx != '0);
            ST_BLEND:   w_bl_start  = 1'b1;
            ST_DONE:    w_out_load  = w_out_free;
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_newest <= '0;
            r_count  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_req.req_type == REQ_PUSH)) begin
                r_newest <= w_wr_addr;
                if (r_count < CW'(SNAP_DEPTH)) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (w_out_load) begin
                r_count <= w_new_count;
            end
        end
    end

    // walk and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_client <= w_client_d[TIME_W] ? '0 : w_client_d[TIME_W-1:0];
                r_ptr    <= r_newest;
                r_idx    <= '0;
                r_mode   <= MODE_EMPTY;
            end
            ST_T_CHECK: begin
                if (!w_future) begin
                    r_past_idx <= r_idx;
                    r_mode     <= (r_idx == '0) ? MODE_PAST : MODE_INTERP;
                end else begin
                    r_fut_t   <= w_rd_time;
                    r_fut_ptr <= r_ptr;
                    if (w_last) begin
                        r_mode <= MODE_FUTURE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        r_ptr <= (r_ptr == '0) ? LAST_SLOT : r_ptr - AW'(1);
                    end
                end
            end
            ST_P_LOAD:  r_past_pos <= w_rd_pos;
            ST_PP_LOAD: begin
                r_past_pos <= w_rd_pos;
                r_ptr      <= r_fut_ptr;
            end
            ST_FP_LOAD: r_fut_pos <= w_rd_pos;
            default: begin
                r_ptr <= r_ptr;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pos  <= w_res_pos;
            r_out_mode <= r_mode;
            r_out_kept <= KEPT_W'(w_new_count);
        end
    end

    // configuration register
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DELAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (w_cfg_wr) begin
            r_delay <= pwdata[DELAY_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DELAY) ? APB_DW'(r_delay) : '0;

    assign i_req.ready       = w_in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_x       = r_out_pos.x;
    assign o_rsp.out_y       = r_out_pos.y;
    assign o_rsp.out_z       = r_out_pos.z;
    assign o_rsp.result_mode = r_out_mode;
    assign o_rsp.kept_count  = r_out_kept;

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for snapshot_interpolator: pushes snapshots, queries delayed positions and
// checks every response transfer against an in-bench model of the snapshot store.
// Depends on snpi_pkg, snpi_if.sv and rtl/snapshot_interpolator.sv.
module testbench;
    import snpi_pkg::*;

    localparam int DEPTH         = SNAP_DEPTH_DEF;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 2500;
    localparam int MAX_PRINTS    = 40;

    localparam logic [APB_AW-1:0] ADDR_DELAY = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_SPARE = 3'd4;

    localparam logic [POS_W-1:0] POS_MIN  = 32'h8000_0000;
    localparam logic [POS_W-1:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_NEG1 = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0] POS_ONE  = 32'h0001_0000;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
        t_mode             mode;
        logic [KEPT_W-1:0] kept;
    } t_answer;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    snpi_req_if req_ch ();
    snpi_rsp_if rsp_ch ();

    snapshot_interpolator DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // snapshot store model
    logic [TIME_W-1:0] snap_t [DEPTH];
    logic [POS_W-1:0]  snap_x [DEPTH];
    logic [POS_W-1:0]  snap_y [DEPTH];
    logic [POS_W-1:0]  snap_z [DEPTH];
    logic [PTR_W-1:0]  head;
    int unsigned       fill;
    logic [DELAY_W-1:0] delay_q;

    t_answer     answers[$];
    int          errors = 0;
    int          pushes = 0;
    int          queries = 0;
    int          results = 0;
    int          mode_hits[4] = '{0, 0, 0, 0};
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_len = 0;
    int          hold_left = 0;
    logic [TIME_W-1:0] cur_time = 32'd1000;

    always #4 clk = ~clk;

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [PTR_W-1:0] slot(input int unsigned age);
        return head - age[PTR_W-1:0];
    endfunction

    function automatic void store_snapshot(input logic [TIME_W-1:0] t,
                                           input logic [POS_W-1:0] x,
                                           input logic [POS_W-1:0] y,
                                           input logic [POS_W-1:0] z);
        head = head + 1'b1;
        snap_t[head] = t;
        snap_x[head] = x;
        snap_y[head] = y;
        snap_z[head] = z;
        if (fill < DEPTH) fill++;
    endfunction

    // past + (future - past) * alpha, step truncated toward zero
    function automatic logic [POS_W-1:0] blend_axis(input logic [POS_W-1:0] past,
                                                    input logic [POS_W-1:0] fut,
                                                    input logic [31:0] alpha);
        logic signed [POS_W:0] ps;
        logic signed [POS_W:0] fs;
        logic signed [POS_W:0] diff;
        logic [POS_W:0]        mag;
        logic [64:0]           prod;
        logic [31:0]           step;
        logic                  neg;
        ps = $signed({past[POS_W-1], past});
        fs = $signed({fut[POS_W-1], fut});
        diff = fs - ps;
        neg = diff < 0;
        mag = neg ? -diff : diff;
        prod = 65'(mag) * 65'(alpha);
        step = prod[63:32];
        return neg ? past - step : past + step;
    endfunction

    function automatic t_answer answer_query(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] client;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] num;
        logic [31:0]       alpha;
        logic [63:0]       quot;
        logic [PTR_W-1:0]  sf;
        logic [PTR_W-1:0]  sp;
        int unsigned       fut;
        int unsigned       past;
        int unsigned       i;
        bit                found;
        t_answer           a;
        client = (now >= {16'h0, delay_q}) ? now - {16'h0, delay_q} : '0;
        a = '0;
        a.mode = MODE_EMPTY;
        if (fill == 0) return a;
        sf = slot(0);
        if (snap_t[sf] <= client) begin
            a.x = snap_x[sf];
            a.y = snap_y[sf];
            a.z = snap_z[sf];
            a.mode = MODE_PAST;
            a.kept = KEPT_W'(fill);
            return a;
        end
        fut = 0;
        past = 0;
        found = 1'b0;
        i = 1;
        while (i < fill && !found) begin
            if (snap_t[slot(i)] > client) begin
                fut = i;
            end else begin
                past = i;
                found = 1'b1;
            end
            i++;
        end
        sf = slot(fut);
        if (!found) begin
            a.x = snap_x[sf];
            a.y = snap_y[sf];
            a.z = snap_z[sf];
            a.mode = MODE_FUTURE;
            a.kept = KEPT_W'(fill);
            return a;
        end
        sp = slot(past);
        span = snap_t[sf] - snap_t[sp];
        num = client - snap_t[sp];
        alpha = '0;
        if (span != 0 && num < span) begin
            quot = {num, 32'h0} / {32'h0, span};
            alpha = quot[31:0];
        end
        a.x = blend_axis(snap_x[sp], snap_x[sf], alpha);
        a.y = blend_axis(snap_y[sp], snap_y[sf], alpha);
        a.z = blend_axis(snap_z[sp], snap_z[sf], alpha);
        fill = past + 1;
        a.mode = MODE_INTERP;
        a.kept = KEPT_W'(fill);
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk) begin
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin : check_results
        t_answer want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results++;
            if (answers.size() == 0) begin
                report_mismatch("response transfer with no query outstanding");
            end else begin
                want = answers.pop_front();
                mode_hits[want.mode]++;
                check_field("out_x", rsp_ch.out_x, want.x);
                check_field("out_y", rsp_ch.out_y, want.y);
                check_field("out_z", rsp_ch.out_z, want.z);
                check_field("result_mode", rsp_ch.result_mode, want.mode);
                check_field("kept_count", rsp_ch.kept_count, want.kept);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [TIME_W-1:0] t,
                             input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [POS_W-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.time_ms  <= t;
        req_ch.in_x     <= x;
        req_ch.in_y     <= y;
        req_ch.in_z     <= z;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        if (kind == REQ_PUSH) begin
            store_snapshot(t, x, y, z);
            pushes++;
        end else begin
            answers.push_back(answer_query(t));
            queries++;
        end
        @(negedge clk);
    endtask

    task automatic push_snap(input logic [TIME_W-1:0] t, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
        send_item(REQ_PUSH, t, x, y, z);
    endtask

    task automatic query_at(input logic [TIME_W-1:0] t);
        send_item(REQ_QUERY, t, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        if (addr[2] == REG_DELAY) delay_q = data[DELAY_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read_check(input logic [APB_AW-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        check_field("prdata", prdata, {16'h0, delay_q});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] next_coord(input logic [POS_W-1:0] prev);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return prev + $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        if (r < 92) return $urandom;
        case ($urandom_range(3))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return '0;
            default: return POS_NEG1;
        endcase
    endfunction

    task automatic random_item();
        logic [TIME_W-1:0] t;
        int unsigned       r;
        int unsigned       pick;
        r = $urandom_range(99);
        if (r < 50) begin
            r = $urandom_range(99);
            if (r < 80) begin
                cur_time = cur_time + $urandom_range(1, 40);
                t = cur_time;
            end else if (r < 92) begin
                t = cur_time - $urandom_range(0, 100);
            end else begin
                t = $urandom;
            end
            push_snap(t, next_coord(snap_x[head]), next_coord(snap_y[head]),
                      next_coord(snap_z[head]));
        end else begin
            r = $urandom_range(99);
            if (fill != 0 && r < 75) begin
                pick = $urandom_range(0, fill - 1);
                t = snap_t[slot(pick)] + $urandom_range(0, 60) - 30 + {16'h0, delay_q};
            end else if (r < 90) begin
                t = cur_time + $urandom_range(0, 300);
            end else begin
                t = $urandom;
            end
            query_at(t);
        end
    endtask

    task automatic test_register_access();
        reg_read_check(ADDR_DELAY);
        reg_write(ADDR_DELAY, 32'hFFFF_FFFF);
        reg_read_check(ADDR_DELAY);
        reg_write(ADDR_SPARE, 32'h0000_1234);
        reg_read_check(ADDR_DELAY);
        reg_write(ADDR_DELAY, 32'h0000_0000);
        reg_read_check(ADDR_DELAY);
        reg_write(ADDR_DELAY, {16'hA5A5, DELAY_RESET});
        reg_read_check(ADDR_DELAY);
    endtask

    task automatic test_empty_store();
        query_at(32'h0000_0000);
        query_at(32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_query_cases();
        push_snap(32'd1000, POS_MIN, POS_MAX, '0);
        push_snap(32'd1100, POS_MAX, POS_MIN, POS_NEG1);
        push_snap(32'd1200, '0, 32'd1, POS_ONE);
        query_at(32'd1400);
        query_at(32'd1000);
        query_at(32'd50);
        query_at(32'd1250);
        query_at(32'd1299);
        query_at(32'd1200);
        // out of order: the walk follows store order
        push_snap(32'd5000, POS_MIN, POS_MIN, POS_MAX);
        push_snap(32'd3000, POS_MAX, POS_MAX, POS_MIN);
        push_snap(32'd7000, POS_MIN, POS_ONE, POS_NEG1);
        query_at(32'd4100);
        push_snap(32'hFFFF_FFFF, POS_MAX, POS_MIN, POS_MAX);
        query_at(32'hFFFF_FFFF);
        push_snap(32'd0, POS_NEG1, POS_MAX, POS_MIN);
        query_at(32'd0);
        query_at(32'd100);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n) random_item();
        wait_drained();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_len = HOLD_CYCLES;
        @(negedge clk);
        // overfill the store, then mix pushes and queries against the held responses
        repeat (20) begin
            cur_time = cur_time + $urandom_range(1, 40);
            push_snap(cur_time, $urandom, $urandom, $urandom);
        end
        repeat (40) random_item();
        wait_drained();
    endtask

    initial begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_PUSH;
        req_ch.time_ms  = '0;
        req_ch.in_x     = '0;
        req_ch.in_y     = '0;
        req_ch.in_z     = '0;
        rsp_ch.ready    = 1'b0;
        head            = '0;
        fill            = 0;
        delay_q         = DELAY_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            snap_t[i] = '0;
            snap_x[i] = '0;
            snap_y[i] = '0;
            snap_z[i] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_access();
        test_empty_store();
        send_idle_pct = 12;
        recv_idle_pct = 45;
        test_query_cases();
        reg_write(ADDR_DELAY, $urandom_range(1, 2000));
        test_random_traffic(540, 12, 45);
        reg_write(ADDR_DELAY, 32'h0000_FFFF);
        test_random_traffic(540, 45, 12);
        reg_write(ADDR_DELAY, 32'h0000_0000);
        test_random_traffic(540, 0, 0);
        reg_write(ADDR_DELAY, $urandom_range(0, 300));
        test_output_stall();

        $display("tb: %0d pushes, %0d queries, %0d responses checked, delays 0 to 65535",
                 pushes, queries, results);
        $display("tb: empty %0d, newest past %0d, interpolated %0d, oldest future %0d",
                 mode_hits[MODE_EMPTY], mode_hits[MODE_PAST], mode_hits[MODE_INTERP],
                 mode_hits[MODE_FUTURE]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
